### src/wrq_pkg.sv
`timescale 1ns / 1ps
package wrq_pkg;

   localparam int WARP_W = 32;

   localparam logic [2:0] KIND_SUBMIT   = 3'd0;
   localparam logic [2:0] KIND_SELECT   = 3'd1;
   localparam logic [2:0] KIND_STALL    = 3'd2;
   localparam logic [2:0] KIND_COMPLETE = 3'd3;
   localparam logic [2:0] KIND_TICK     = 3'd4;

   localparam logic [2:0] REG_ACTIVE_UNITS  = 3'd0;
   localparam logic [2:0] REG_POLICY_MODE   = 3'd1;
   localparam logic [2:0] REG_WARPS_MAX     = 3'd2;
   localparam logic [2:0] REG_BATCH_LIMIT   = 3'd3;
   localparam logic [2:0] REG_REBALANCE_EN  = 3'd4;

   localparam logic [1:0] POLICY_ROUND_ROBIN = 2'd0;

   localparam logic [2:0] RST_ACTIVE_UNITS = 3'd4;
   localparam logic [1:0] RST_POLICY_MODE  = 2'd2;
   localparam logic [4:0] RST_WARPS_MAX    = 5'd16;
   localparam logic [4:0] RST_BATCH_LIMIT  = 5'd4;
   localparam logic       RST_REBALANCE_EN = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_SHARE,
      ST_DIV,
      ST_FILL,
      ST_MOD,
      ST_TAKE,
      ST_STALL,
      ST_TICK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic push;
      logic take;
   } list_ctl_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

### src/wrq_cell.sv
`timescale 1ns / 1ps
module wrq_cell (
   input  logic                        clock,
   input  wrq_pkg::cell_ctl_type       ctl,
   input  logic [wrq_pkg::WARP_W-1:0]  load_data,
   input  logic [wrq_pkg::WARP_W-1:0]  next_data,
   output logic [wrq_pkg::WARP_W-1:0]  value
);

   logic [wrq_pkg::WARP_W-1:0] value_ff;
   logic [wrq_pkg::WARP_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = next_data;
      end else if (ctl.load) begin
         value_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### src/wrq_list.sv
`timescale 1ns / 1ps
module wrq_list #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wrq_pkg::list_ctl_type                 ctl,
   input  logic [$clog2(LIST_DEPTH)-1:0]         pos,
   input  logic [wrq_pkg::WARP_W-1:0]            push_data,
   output logic [$clog2(LIST_DEPTH+1)-1:0]       length,
   output logic                                  full,
   output logic [wrq_pkg::WARP_W-1:0]            sel_data
);

   localparam int PW = $clog2(LIST_DEPTH);
   localparam int LW = $clog2(LIST_DEPTH + 1);

   logic [LW-1:0]                len_ff;
   logic [LW-1:0]                len_in;
   logic                         push_ok;
   logic [wrq_pkg::WARP_W-1:0]   values [LIST_DEPTH];

   assign full    = (len_ff == LW'(LIST_DEPTH));
   assign push_ok = ctl.push && !full;
   assign length  = len_ff;

   // Removing an entry makes every cell at or past it take its right neighbor.
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      wrq_pkg::cell_ctl_type       cctl;
      logic [wrq_pkg::WARP_W-1:0]  nxt;

      assign cctl.shift = ctl.take && (PW'(i) >= pos);
      assign cctl.load  = push_ok && (len_ff == LW'(i));
      if (i == LIST_DEPTH - 1) begin : g_last
         assign nxt = values[i];
      end else begin : g_mid
         assign nxt = values[i+1];
      end

      wrq_cell u_cell (
         .clock     (clock),
         .ctl       (cctl),
         .load_data (push_data),
         .next_data (nxt),
         .value     (values[i])
      );
   end

   assign sel_data = values[pos];

   always_comb begin
      len_in = len_ff;
      if (push_ok) begin
         len_in = len_ff + LW'(1);
      end else if (ctl.take) begin
         len_in = len_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

endmodule

### src/warp_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// request   start, busy, req_*                      taken when start is high and busy low
// result    rsp_valid, rsp_*                        one-cycle strobe, always taken
// config    csr_valid, csr_ready, csr_index/data    written when valid and ready are high
//
// Complete, unknown and rejected requests go from decode straight to done; stall, tick
// (rebalance on) and fifo select first pass through ST_STALL, ST_TICK or ST_TAKE.
// Round-robin select first runs a subtract loop that wraps the rotate index. Submit
// multiplies the grid, sets the share from the cap or divides it out, then fills the
// lists, one warp pushed per cycle; a zero share still passes through the fill state.
// Reset is synchronous and empties all lists; the receiver cannot stall.
module warp_ready_queue_scheduler #(
   parameter int NUM_UNITS  = 4,
   parameter int LIST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_unit,
   input  logic [15:0] req_grid_width,
   input  logic [15:0] req_grid_height,
   input  logic [31:0] req_warp_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_warp_out,
   output logic        rsp_warp_found,
   output logic        rsp_dropped,
   output logic        rsp_unit_has_ready,
   output logic        rsp_all_empty,
   output logic [31:0] rsp_dispatch_total,
   output logic [31:0] rsp_complete_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int PW = $clog2(LIST_DEPTH);
   localparam int LW = $clog2(LIST_DEPTH + 1);
   localparam int CW = (LW > 5) ? LW : 5;

   wrq_pkg::state_type state_ff, state_in;

   logic [2:0]  active_units_ff;
   logic [1:0]  policy_ff;
   logic [4:0]  warps_max_ff;
   logic [4:0]  batch_ff;
   logic        rebalance_ff;

   logic [2:0]  kind_ff;
   logic [7:0]  unit_ff;
   logic [15:0] gw_ff;
   logic [15:0] gh_ff;
   logic [31:0] warp_in_ff;

   logic [31:0] prod_ff;
   logic [7:0]  quo_ff;
   logic [3:0]  rem_ff;
   logic [2:0]  step_ff;
   logic [4:0]  count_ff;
   logic [4:0]  i_ff;
   logic [2:0]  u_ff;
   logic [LW-1:0] mod_ff;
   logic [PW-1:0] pos_ff;

   logic [31:0] next_warp_ff;
   logic [31:0] dispatch_ff;
   logic [31:0] complete_ff;
   logic [31:0] warp_out_ff;
   logic        found_ff;
   logic        dropped_ff;

   logic [PW-1:0] rot_ff [NUM_UNITS];

   logic [LW-1:0] ready_len  [NUM_UNITS];
   logic [LW-1:0] stall_len  [NUM_UNITS];
   logic          ready_full [NUM_UNITS];
   logic          stall_full [NUM_UNITS];
   logic [31:0]   ready_sel  [NUM_UNITS];
   logic [31:0]   stall_head [NUM_UNITS];

   logic [2:0]    nu;
   logic          unit_ok;
   logic [LW-1:0] sel_len;
   logic [PW-1:0] sel_rot;
   logic [31:0]   sel_data;
   logic          sel_stall_full;
   logic          fill_full;
   logic          any_busy_list;
   logic          share_ge;
   logic [4:0]    div_t;
   logic          div_ge;
   logic [7:0]    quo_next;
   logic          fill_last_i;
   logic          fill_last_u;

   assign nu = (5'(active_units_ff) > 5'(NUM_UNITS)) ? 3'(NUM_UNITS) : active_units_ff;
   assign unit_ok = (unit_ff < 8'(nu));

   // Share is min(cap, g*32/units); the cap wins whenever g*32 >= cap*units.
   assign share_ge = ({prod_ff, 5'b0} >= 37'(8'(warps_max_ff) * 8'(nu)));
   assign div_t    = {rem_ff, quo_ff[7]};
   assign div_ge   = (div_t >= {2'b0, nu});
   assign quo_next = {quo_ff[6:0], div_ge};

   assign fill_last_i = (i_ff == count_ff - 5'd1);
   assign fill_last_u = (u_ff == nu - 3'd1);

   for (genvar k = 0; k < NUM_UNITS; k++) begin : g_unit
      logic                  hit;
      logic                  fill_hit;
      logic                  active;
      logic                  move;
      wrq_pkg::list_ctl_type rctl;
      wrq_pkg::list_ctl_type sctl;
      logic [31:0]           rdata;

      assign hit      = (unit_ff == 8'(k));
      assign fill_hit = (8'(u_ff) == 8'(k));
      assign active   = (8'(k) < 8'(nu));
      assign move     = (state_ff == wrq_pkg::ST_TICK) && active && (stall_len[k] != '0)
                        && (CW'(ready_len[k]) < CW'(batch_ff)) && !ready_full[k];

      assign rctl.push = ((state_ff == wrq_pkg::ST_FILL) && (count_ff != 5'd0) && fill_hit)
                         || move;
      assign rctl.take = (state_ff == wrq_pkg::ST_TAKE) && hit;
      assign sctl.push = (state_ff == wrq_pkg::ST_STALL) && hit;
      assign sctl.take = move;
      assign rdata     = (state_ff == wrq_pkg::ST_TICK) ? stall_head[k] : next_warp_ff;

      wrq_list #(.LIST_DEPTH(LIST_DEPTH)) u_ready (
         .clock     (clock),
         .reset     (reset),
         .ctl       (rctl),
         .pos       (pos_ff),
         .push_data (rdata),
         .length    (ready_len[k]),
         .full      (ready_full[k]),
         .sel_data  (ready_sel[k])
      );

      wrq_list #(.LIST_DEPTH(LIST_DEPTH)) u_stall (
         .clock     (clock),
         .reset     (reset),
         .ctl       (sctl),
         .pos       ('0),
         .push_data (warp_in_ff),
         .length    (stall_len[k]),
         .full      (stall_full[k]),
         .sel_data  (stall_head[k])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            rot_ff[k] <= '0;
         end else if ((state_ff == wrq_pkg::ST_MOD) && hit && (mod_ff < sel_len)) begin
            rot_ff[k] <= mod_ff[PW-1:0];
         end
      end
   end

   always_comb begin
      sel_len        = '0;
      sel_rot        = '0;
      sel_data       = '0;
      sel_stall_full = 1'b0;
      fill_full      = 1'b0;
      any_busy_list  = 1'b0;
      for (int k = 0; k < NUM_UNITS; k++) begin
         if (unit_ff == 8'(k)) begin
            sel_len        = ready_len[k];
            sel_rot        = rot_ff[k];
            sel_data       = ready_sel[k];
            sel_stall_full = stall_full[k];
         end
         if (8'(u_ff) == 8'(k)) begin
            fill_full = ready_full[k];
         end
         if ((ready_len[k] != '0) || (stall_len[k] != '0)) begin
            any_busy_list = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = wrq_pkg::ST_DECODE;
            end
         end
         wrq_pkg::ST_DECODE: begin
            priority if ((kind_ff == wrq_pkg::KIND_SUBMIT) && (nu != 3'd0)) begin
               state_in = wrq_pkg::ST_MUL;
            end else if ((kind_ff == wrq_pkg::KIND_SELECT) && unit_ok && (sel_len != '0)) begin
               state_in = (policy_ff == wrq_pkg::POLICY_ROUND_ROBIN) ?
                          wrq_pkg::ST_MOD : wrq_pkg::ST_TAKE;
            end else if ((kind_ff == wrq_pkg::KIND_STALL) && unit_ok) begin
               state_in = wrq_pkg::ST_STALL;
            end else if ((kind_ff == wrq_pkg::KIND_TICK) && rebalance_ff) begin
               state_in = wrq_pkg::ST_TICK;
            end else begin
               state_in = wrq_pkg::ST_DONE;
            end
         end
         wrq_pkg::ST_MUL:   state_in = wrq_pkg::ST_SHARE;
         wrq_pkg::ST_SHARE: state_in = share_ge ? wrq_pkg::ST_FILL : wrq_pkg::ST_DIV;
         wrq_pkg::ST_DIV: begin
            if (step_ff == 3'd7) begin
               state_in = wrq_pkg::ST_FILL;
            end
         end
         wrq_pkg::ST_FILL: begin
            if ((count_ff == 5'd0) || (fill_last_i && fill_last_u)) begin
               state_in = wrq_pkg::ST_DONE;
            end
         end
         wrq_pkg::ST_MOD: begin
            if (mod_ff < sel_len) begin
               state_in = wrq_pkg::ST_TAKE;
            end
         end
         wrq_pkg::ST_TAKE:  state_in = wrq_pkg::ST_DONE;
         wrq_pkg::ST_STALL: state_in = wrq_pkg::ST_DONE;
         wrq_pkg::ST_TICK:  state_in = wrq_pkg::ST_DONE;
         wrq_pkg::ST_DONE:  state_in = wrq_pkg::ST_IDLE;
         default:           state_in = wrq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy               = (state_ff != wrq_pkg::ST_IDLE);
      rsp_valid          = (state_ff == wrq_pkg::ST_DONE);
      rsp_warp_out       = warp_out_ff;
      rsp_warp_found     = found_ff;
      rsp_dropped        = dropped_ff;
      rsp_unit_has_ready = unit_ok && (sel_len != '0);
      rsp_all_empty      = !any_busy_list;
      rsp_dispatch_total = dispatch_ff;
      rsp_complete_total = complete_ff;
      csr_ready          = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= wrq_pkg::ST_IDLE;
         active_units_ff <= wrq_pkg::RST_ACTIVE_UNITS;
         policy_ff       <= wrq_pkg::RST_POLICY_MODE;
         warps_max_ff    <= wrq_pkg::RST_WARPS_MAX;
         batch_ff        <= wrq_pkg::RST_BATCH_LIMIT;
         rebalance_ff    <= wrq_pkg::RST_REBALANCE_EN;
         next_warp_ff    <= '0;
         dispatch_ff     <= '0;
         complete_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               wrq_pkg::REG_ACTIVE_UNITS: active_units_ff <= csr_data[2:0];
               wrq_pkg::REG_POLICY_MODE:  policy_ff       <= csr_data[1:0];
               wrq_pkg::REG_WARPS_MAX:    warps_max_ff    <= csr_data[4:0];
               wrq_pkg::REG_BATCH_LIMIT:  batch_ff        <= csr_data[4:0];
               wrq_pkg::REG_REBALANCE_EN: rebalance_ff    <= csr_data[0];
               default: ;
            endcase
         end
         if ((state_ff == wrq_pkg::ST_DECODE) && (kind_ff == wrq_pkg::KIND_COMPLETE)) begin
            complete_ff <= complete_ff + 32'd1;
         end
         if ((state_ff == wrq_pkg::ST_FILL) && (count_ff != 5'd0)) begin
            next_warp_ff <= next_warp_ff + 32'd1;
         end
         if (state_ff == wrq_pkg::ST_TAKE) begin
            dispatch_ff <= dispatch_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         wrq_pkg::ST_IDLE: begin
            kind_ff     <= req_kind;
            unit_ff     <= req_unit;
            gw_ff       <= req_grid_width;
            gh_ff       <= req_grid_height;
            warp_in_ff  <= req_warp_in;
            warp_out_ff <= '0;
            found_ff    <= 1'b0;
            dropped_ff  <= 1'b0;
         end
         wrq_pkg::ST_DECODE: begin
            mod_ff <= LW'(sel_rot) + LW'(1);
            pos_ff <= '0;
         end
         wrq_pkg::ST_MUL: begin
            prod_ff <= 32'(gw_ff) * 32'(gh_ff);
         end
         wrq_pkg::ST_SHARE: begin
            count_ff <= warps_max_ff;
            quo_ff   <= {prod_ff[2:0], 5'b0};
            rem_ff   <= '0;
            step_ff  <= '0;
            i_ff     <= '0;
            u_ff     <= '0;
         end
         wrq_pkg::ST_DIV: begin
            rem_ff   <= div_ge ? 4'(div_t - {2'b0, nu}) : div_t[3:0];
            quo_ff   <= quo_next;
            step_ff  <= step_ff + 3'd1;
            count_ff <= quo_next[4:0];
         end
         wrq_pkg::ST_FILL: begin
            if (count_ff != 5'd0) begin
               if (fill_full) begin
                  dropped_ff <= 1'b1;
               end
               if (fill_last_i) begin
                  i_ff <= '0;
                  u_ff <= u_ff + 3'd1;
               end else begin
                  i_ff <= i_ff + 5'd1;
               end
            end
         end
         wrq_pkg::ST_MOD: begin
            if (mod_ff >= sel_len) begin
               mod_ff <= mod_ff - sel_len;
            end else begin
               pos_ff <= mod_ff[PW-1:0];
            end
         end
         wrq_pkg::ST_TAKE: begin
            warp_out_ff <= sel_data;
            found_ff    <= 1'b1;
         end
         wrq_pkg::ST_STALL: begin
            if (sel_stall_full) begin
               dropped_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wrq_pkg::ST_TAKE) |-> (sel_len != '0))
      else $error("select removed from an empty ready list");

   a_found_after_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_warp_found) |-> ($past(state_ff) == wrq_pkg::ST_TAKE))
      else $error("found flag without a removal");

endmodule
